@@ rtl/prefixed_number_parser_defines.svh @@
// ----------------------------------------------------------------------------
// Prefixed number parser assertion macros
// Clocked property shorthands shared by the parser queue and back end.
// ----------------------------------------------------------------------------
`ifndef PREFIXED_NUMBER_PARSER_DEFINES_SVH
`define PREFIXED_NUMBER_PARSER_DEFINES_SVH

// same-cycle implication, off during reset
`define PNP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PNP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pnp_pkg.sv @@
// ----------------------------------------------------------------------------
// Prefixed number parser package
// Shared constants, character codes, request and result types.
// ----------------------------------------------------------------------------
package pnp_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_X       = 8'h78;

    localparam logic [4:0] BASE_2  = 5'd2;
    localparam logic [4:0] BASE_8  = 5'd8;
    localparam logic [4:0] BASE_10 = 5'd10;
    localparam logic [4:0] BASE_16 = 5'd16;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_MISSING   = 3'd1;
    localparam logic [2:0] STATUS_BADPREFIX = 3'd2;
    localparam logic [2:0] STATUS_OVERFLOW  = 3'd3;
    localparam logic [2:0] STATUS_INVALID   = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [4:0]  base;
        logic [8:0]  consumed;
    } t_out_res;

    typedef struct packed {
        logic       nul;
        logic       zero;
        logic       hex;
        logic [3:0] dig;
        logic       sym_ok;
        logic [4:0] sym_base;
        logic       let_ok;
        logic [4:0] let_base;
        logic       last;
    } t_cls;

endpackage

@@ rtl/pnp_front.sv @@
// ----------------------------------------------------------------------------
// Prefixed number parser front end
// Accepts character requests and classifies them for the parse queue.
// ----------------------------------------------------------------------------
module pnp_front
    import pnp_pkg::*;
(
    input  logic    i_in_valid,
    input  t_in_req i_in,
    output logic    o_in_stall,
    output logic    o_push,
    output t_cls    o_push_ent,
    input  logic    i_full
);

    logic [7:0] w_c;
    logic       w_dec;
    logic       w_lo;
    logic       w_up;

    assign w_c   = i_in.char_code;
    assign w_dec = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_lo  = (w_c >= CH_LO_A) && (w_c <= CH_LO_F);
    assign w_up  = (w_c >= CH_UP_A) && (w_c <= CH_UP_F);

    always_comb begin
        o_push_ent          = '0;
        o_push_ent.last     = i_in.last;
        o_push_ent.nul      = (w_c == CH_NUL);
        o_push_ent.zero     = (w_c == CH_ZERO);
        o_push_ent.hex      = w_dec || w_lo || w_up;
        o_push_ent.dig      = w_dec ? w_c[3:0] : 4'(w_c[3:0] + 4'd9);
        o_push_ent.sym_ok   = 1'b1;
        o_push_ent.sym_base = BASE_10;
        unique case (w_c)
            CH_PERCENT: o_push_ent.sym_base = BASE_2;
            CH_HASH:    o_push_ent.sym_base = BASE_10;
            CH_DOLLAR:  o_push_ent.sym_base = BASE_16;
            default:    o_push_ent.sym_ok   = 1'b0;
        endcase
        o_push_ent.let_ok   = 1'b1;
        o_push_ent.let_base = BASE_10;
        unique case (w_c) inside
            CH_B:       o_push_ent.let_base = BASE_2;
            CH_O:       o_push_ent.let_base = BASE_8;
            CH_D:       o_push_ent.let_base = BASE_10;
            CH_H, CH_X: o_push_ent.let_base = BASE_16;
            default:    o_push_ent.let_ok   = 1'b0;
        endcase
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

@@ rtl/pnp_queue.sv @@
// ----------------------------------------------------------------------------
// Prefixed number parser queue
// Short register queue of classified characters between front and back.
// ----------------------------------------------------------------------------
`include "prefixed_number_parser_defines.svh"

module pnp_queue
    import pnp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_push_ent,
    output logic o_full,
    input  logic i_pop,
    output t_cls o_pop_ent,
    output logic o_empty
);

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_ent;
        end
    end

    assign o_pop_ent = r_mem[r_rd_ptr];
    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);

    `PNP_ASSERT_IMP(a_cnt_bound, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
    `PNP_ASSERT_NXT(a_cnt_inc, i_push && !i_pop, r_count == $past(r_count) + QCNT_W'(1), "lost push")
    `PNP_ASSERT_IMP(a_pop_nonempty, i_pop, r_count != '0, "pop from empty queue")

endmodule

@@ rtl/pnp_back.sv @@
// ----------------------------------------------------------------------------
// Prefixed number parser back end
// Runs the base selection and digit accumulation and registers the result.
// ----------------------------------------------------------------------------
`include "prefixed_number_parser_defines.svh"

module pnp_back
    import pnp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cls     i_ent,
    input  logic     i_empty,
    output logic     o_pop,
    output logic     o_out_valid,
    output t_out_res o_out,
    input  logic     i_out_stall
);

    localparam int               POS_W   = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

    localparam logic [2:0] PH_START      = 3'd0;
    localparam logic [2:0] PH_AFTER_ZERO = 3'd1;
    localparam logic [2:0] PH_DIGITS     = 3'd2;
    localparam logic [2:0] PH_DONE       = 3'd3;
    localparam logic [2:0] PH_MISSING    = 3'd4;
    localparam logic [2:0] PH_BADPREFIX  = 3'd5;

    logic [2:0]       r_phase, n_phase;
    logic [63:0]      r_acc, n_acc;
    logic [4:0]       r_base, n_base;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_seen, n_seen;
    logic             r_ovf, n_ovf;
    logic             r_out_valid;
    t_out_res         r_out;
    t_out_res         w_res;

    logic             w_take;
    logic             w_dig_ok;
    logic [67:0]      w_mul;
    logic [67:0]      w_sum;
    logic [POS_W+8:0] w_pos_ext;

    logic             w_chk_ok;
    logic             w_chk_err;
    logic             w_chk_hold;

    always_comb begin
        case (r_base)
            BASE_2:  w_mul = {3'b0, r_acc, 1'b0};
            BASE_8:  w_mul = {1'b0, r_acc, 3'b0};
            BASE_16: w_mul = {r_acc, 4'b0};
            default: w_mul = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0};
        endcase
        w_sum = w_mul + {64'd0, i_ent.dig};
    end

    assign w_dig_ok = (r_pos < MAX_POS) && !i_ent.nul && i_ent.hex
                      && ({1'b0, i_ent.dig} < r_base);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_base  = r_base;
        n_pos   = r_pos;
        n_seen  = r_seen;
        n_ovf   = r_ovf;
        w_take  = 1'b0;
        unique case (r_phase)
            PH_START: begin
                if (i_ent.nul) begin
                    n_phase = PH_MISSING;
                end else if (i_ent.zero) begin
                    n_base  = BASE_10;
                    n_acc   = '0;
                    n_seen  = 1'b1;
                    n_pos   = POS_W'(1);
                    n_phase = PH_AFTER_ZERO;
                end else if (i_ent.hex) begin
                    n_base  = BASE_10;
                    n_phase = PH_DIGITS;
                    w_take  = 1'b1;
                end else if (i_ent.sym_ok) begin
                    n_base  = i_ent.sym_base;
                    n_pos   = POS_W'(1);
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_BADPREFIX;
                end
            end
            PH_AFTER_ZERO: begin
                if (i_ent.let_ok) begin
                    n_base  = i_ent.let_base;
                    n_seen  = 1'b0;
                    n_pos   = POS_W'(2);
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DIGITS;
                    w_take  = 1'b1;
                end
            end
            PH_DIGITS: begin
                w_take = 1'b1;
            end
            default: begin
            end
        endcase
        if (w_take) begin
            if (w_dig_ok) begin
                n_acc  = w_sum[63:0];
                n_ovf  = r_ovf || (w_sum[67:64] != 4'd0);
                n_seen = 1'b1;
                n_pos  = r_pos + POS_W'(1);
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    assign w_pos_ext = {9'd0, n_pos};

    always_comb begin
        w_res          = '0;
        w_res.base     = BASE_10;
        w_res.status   = STATUS_OK;
        if (n_phase == PH_MISSING) begin
            w_res.status = STATUS_MISSING;
        end else if (n_phase == PH_BADPREFIX) begin
            w_res.status = STATUS_BADPREFIX;
        end else begin
            w_res.base = n_base;
            if (n_ovf) begin
                w_res.status = STATUS_OVERFLOW;
            end else if (!n_seen) begin
                w_res.status = STATUS_INVALID;
            end else begin
                w_res.value    = n_acc[31:0];
                w_res.consumed = w_pos_ext[8:0];
            end
        end
    end

    assign o_pop = !i_empty && (!i_ent.last || !r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_acc       <= '0;
            r_base      <= BASE_10;
            r_pos       <= '0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_ent.last) begin
                r_phase     <= PH_START;
                r_acc       <= '0;
                r_base      <= BASE_10;
                r_pos       <= '0;
                r_seen      <= 1'b0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (o_pop) begin
                    r_phase <= n_phase;
                    r_acc   <= n_acc;
                    r_base  <= n_base;
                    r_pos   <= n_pos;
                    r_seen  <= n_seen;
                    r_ovf   <= n_ovf;
                end
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_ent.last) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_chk_ok   = r_out_valid && (r_out.status == STATUS_OK);
    assign w_chk_err  = r_out_valid && ((r_out.status == STATUS_MISSING)
                        || (r_out.status == STATUS_BADPREFIX));
    assign w_chk_hold = (r_phase == PH_DONE) && !(o_pop && i_ent.last);

    `PNP_ASSERT_IMP(a_ok_consumed, w_chk_ok, r_out.consumed != '0, "empty ok result")
    `PNP_ASSERT_IMP(a_err_base, w_chk_err, r_out.base == BASE_10, "error result not decimal")
    `PNP_ASSERT_NXT(a_done_hold, w_chk_hold, (r_phase == PH_DONE) && $stable(r_pos), "parse moved")

endmodule

@@ rtl/prefixed_number_parser.sv @@
// ----------------------------------------------------------------------------
// Prefixed number parser
// Parses a character stream into a number with base prefix selection.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | request   | i_in_valid / o_in_stall  | t_in_req  (char_code, last)
//  out     | result    | o_out_valid / i_out_stall| t_out_res (status, value, base, consumed)
//
//  One character per cycle sustained while no result waits under i_out_stall:
//  the back end takes one queued character a cycle and registers each result.
//  Reset (i_rst_n low, synchronous) empties the queue and clears the parse.
//  While a result waits under i_out_stall, non-last characters keep flowing;
//  a last character waits in the two-entry queue, and o_in_stall rises when
//  the queue is full.
// ----------------------------------------------------------------------------
module prefixed_number_parser
    import pnp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out
);

    logic w_push;
    t_cls w_push_ent;
    logic w_full;
    logic w_pop;
    t_cls w_pop_ent;
    logic w_empty;

    pnp_front u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_push_ent (w_push_ent),
        .i_full     (w_full)
    );

    pnp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_ent (w_push_ent),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_pop_ent  (w_pop_ent),
        .o_empty    (w_empty)
    );

    pnp_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent       (w_pop_ent),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ dv/prefixed_number_parser_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefixed number parser checker
// Watches both channels, predicts one result for every request marked last
// and compares each delivered result field by field with the oldest one.
// ----------------------------------------------------------------------------
module prefixed_number_parser_checker
    import pnp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_res i_out,
    output int       o_errors,
    output int       o_pending
);

    localparam int unsigned NOT_DIGIT = 99;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_AFTER_ZERO,
        SCAN_DIGITS,
        SCAN_DONE,
        SCAN_MISSING,
        SCAN_BADPREFIX
    } t_scan;

    t_scan       scan;
    logic [63:0] acc;
    logic [4:0]  num_base;
    int unsigned pos;
    logic        saw_digit;
    logic        ovf;
    t_out_res    parsed_q[$];
    int          err_count = 0;

    assign o_errors = err_count;

    function automatic int unsigned char_digit(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LO_A && c <= CH_LO_A + 8'd25) return c - CH_LO_A + 10;
        if (c >= CH_UP_A && c <= CH_UP_A + 8'd25) return c - CH_UP_A + 10;
        return NOT_DIGIT;
    endfunction

    function automatic void clear_scan();
        scan      = SCAN_START;
        acc       = '0;
        num_base  = BASE_10;
        pos       = 0;
        saw_digit = 1'b0;
        ovf       = 1'b0;
    endfunction

    function automatic void add_digit(logic [7:0] c);
        int unsigned d;
        logic [63:0] limit;
        d = char_digit(c);
        if (pos >= MAX_LEN_DEF || c == CH_NUL || d >= num_base) begin
            scan = SCAN_DONE;
            return;
        end
        limit = (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(num_base);
        if (acc > limit) ovf = 1'b1;
        acc       = acc * 64'(num_base) + 64'(d);
        saw_digit = 1'b1;
        pos++;
    endfunction

    function automatic bit parse_char(t_in_req r, output t_out_res res);
        logic [7:0] c;
        c   = r.char_code;
        res = '{status: STATUS_OK, value: '0, base: BASE_10, consumed: '0};
        case (scan)
            SCAN_START: begin
                if (c == CH_NUL) begin
                    scan = SCAN_MISSING;
                end else if (c == CH_ZERO) begin
                    num_base  = BASE_10;
                    acc       = '0;
                    saw_digit = 1'b1;
                    pos       = 1;
                    scan      = SCAN_AFTER_ZERO;
                end else if (char_digit(c) < 16) begin
                    num_base = BASE_10;
                    scan     = SCAN_DIGITS;
                    add_digit(c);
                end else if (c == CH_PERCENT || c == CH_HASH || c == CH_DOLLAR) begin
                    num_base = (c == CH_PERCENT) ? BASE_2 : (c == CH_HASH) ? BASE_10 : BASE_16;
                    pos      = 1;
                    scan     = SCAN_DIGITS;
                end else begin
                    scan = SCAN_BADPREFIX;
                end
            end
            SCAN_AFTER_ZERO: begin
                if (c == CH_B || c == CH_O || c == CH_D || c == CH_H || c == CH_X) begin
                    num_base  = (c == CH_B) ? BASE_2 : (c == CH_O) ? BASE_8
                              : (c == CH_D) ? BASE_10 : BASE_16;
                    saw_digit = 1'b0;
                    pos       = 2;
                    scan      = SCAN_DIGITS;
                end else begin
                    scan = SCAN_DIGITS;
                    add_digit(c);
                end
            end
            SCAN_DIGITS: add_digit(c);
            default: ;
        endcase
        if (!r.last) return 1'b0;
        if (scan == SCAN_MISSING) begin
            res.status = STATUS_MISSING;
        end else if (scan == SCAN_BADPREFIX) begin
            res.status = STATUS_BADPREFIX;
        end else begin
            res.base = num_base;
            if (ovf) begin
                res.status = STATUS_OVERFLOW;
            end else if (!saw_digit) begin
                res.status = STATUS_INVALID;
            end else begin
                res.value    = acc[31:0];
                res.consumed = 9'(pos);
            end
        end
        clear_scan();
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t parser %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_res want;
        if (!i_rst_n) begin
            clear_scan();
            parsed_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (parsed_q.size() == 0) begin
                    $display("%0t parser result with no request pending: expected none, actual %h",
                             $time, i_out);
                    err_count++;
                end else begin
                    want = parsed_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out.status));
                    check_field("value", want.value, i_out.value);
                    check_field("base", 32'(want.base), 32'(i_out.base));
                    check_field("consumed", 32'(want.consumed), 32'(i_out.consumed));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (parse_char(i_in, want)) parsed_q.push_back(want);
            end
        end
        o_pending <= parsed_q.size();
    end

endmodule

@@ dv/prefixed_number_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefixed number parser testbench
// Sends directed and random character strings in bursts, stalls the result
// side on its own pattern and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module prefixed_number_parser_test;
    import pnp_pkg::*;

    localparam int ITEM_TARGET = 1750;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_in_req  in_req    = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_out_res out_res;
    int       errors;
    int       pending;
    logic     hold_go   = 1'b0;
    int       burst_left = 0;
    int       items_sent = 0;
    logic [7:0] text[$];

    prefixed_number_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    prefixed_number_parser_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_res),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_char(logic [7:0] c, logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_req   <= '{char_code: c, last: lst};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text();
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic void load_text(string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] digit_char(int unsigned d);
        if (d < 10) return CH_ZERO + 8'(d);
        if ($urandom_range(0, 1) == 0) return CH_LO_A + 8'(d - 10);
        return CH_UP_A + 8'(d - 10);
    endfunction

    function automatic void build_random_literal();
        logic [4:0] num_base;
        int         ndig;
        int         r;
        text.delete();
        num_base = BASE_10;
        if ($urandom_range(0, 99) < 10) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 11))
            0: text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            1: text.push_back(CH_ZERO);
            2: begin num_base = BASE_2;  text = '{CH_ZERO, CH_B}; end
            3: begin num_base = BASE_8;  text = '{CH_ZERO, CH_O}; end
            4: begin num_base = BASE_10; text = '{CH_ZERO, CH_D}; end
            5: begin num_base = BASE_16; text = '{CH_ZERO, CH_H}; end
            6: begin num_base = BASE_16; text = '{CH_ZERO, CH_X}; end
            7: begin num_base = BASE_2;  text = '{CH_PERCENT}; end
            8: begin num_base = BASE_10; text = '{CH_HASH}; end
            9: begin num_base = BASE_16; text = '{CH_DOLLAR}; end
            10: begin
                num_base = BASE_16;
                text.push_back(digit_char($urandom_range(10, 15)));
            end
            default: text = '{CH_NUL};
        endcase
        if ($urandom_range(0, 99) < 2) begin
            repeat ($urandom_range(200, 300)) text.push_back(CH_ZERO);
        end
        r = $urandom_range(0, 99);
        ndig = (r < 8) ? 0 : (r < 70) ? $urandom_range(1, 10)
             : (r < 92) ? $urandom_range(11, 24) : $urandom_range(25, 70);
        repeat (ndig) text.push_back(digit_char($urandom_range(0, num_base - 1)));
        r = $urandom_range(0, 99);
        if (r < 20) text.push_back(CH_NUL);
        else if (r < 50) text.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
        if (text.size() == 0) text.push_back(CH_ZERO);
    endfunction

    // result side: random stall segments, one long hold-off once the random part runs
    initial begin
        int pct;
        bit held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_go && !held) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                held = 1'b1;
            end
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 30;
                2: pct = 60;
                default: pct = 90;
            endcase
            repeat ($urandom_range(5, 40)) begin
                out_stall <= ($urandom_range(0, 99) < pct);
                @(posedge clk);
            end
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        text = '{CH_NUL};
        send_text();
        load_text("0");
        send_text();
        load_text("0x");
        send_text();
        load_text("$");
        send_text();
        load_text("a");
        send_text();
        text = '{8'hFF};
        send_text();
        load_text("$FfFfFfFfFfFfFfFfF");
        send_text();
        load_text("0o7+1");
        send_text();
        wait_drained();

        hold_go <= 1'b1;
        while (items_sent < ITEM_TARGET) begin
            build_random_literal();
            send_text();
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
        wait_drained();
        repeat (10) @(posedge clk);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pnp_pkg.sv
rtl/pnp_front.sv
rtl/pnp_queue.sv
rtl/pnp_back.sv
rtl/prefixed_number_parser.sv
dv/prefixed_number_parser_checker.sv
dv/prefixed_number_parser_test.sv
